// ===== src/lbc_pkg.sv =====
// Shared constants for the line clipper: default width, register indexes and window reset values.
`timescale 1ns / 1ps
package lbc_pkg;

    localparam int COORD_BITS_DEF = 12;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TOP    = 2'd3;

    // window reset values
    localparam int LEFT_RST   = 0;
    localparam int RIGHT_RST  = 1023;
    localparam int BOTTOM_RST = 0;
    localparam int TOP_RST    = 719;

endpackage

// ===== src/liang_barsky_line_clip.sv =====
// Liang-Barsky segment clipper against a configurable window, fully pipelined.
// The pipeline holds COORD_BITS + 6 stages from the capture of an accepted request
//   to its registered result on m_tvalid.
// Throughput: one segment per cycle while m_tready does not stall the output; the
//   divider pipeline (one quotient bit per stage, four dividers side by side) sets the depth.
// Each stage holds when the one after it is full and stalled; bubbles collapse.
// Reset (aresetn low, synchronous) empties the pipeline and loads the window
//   with left 0, right 1023, bottom 0, top 719.
`timescale 1ns / 1ps
module liang_barsky_line_clip import lbc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // segment request
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // from bit 0 up: start_x, start_y, end_x, end_y
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // clipped result
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // from bit 0 up: exit_x, exit_y, entry_x, entry_y
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
    output logic                    m_tuser,   // visible
    // window register writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [COORD_BITS-1:0]   cfg_data
);
    localparam int W   = COORD_BITS;
    localparam int CW  = W + 1;          // differences, ratio terms
    localparam int PW  = 2 * W + 2;      // cross products
    localparam int NW  = 2 * W + 3;      // point numerators
    localparam int DS  = 4;              // first divider stage
    localparam int OS  = DS + W + 1;     // output stage
    localparam int NST = OS + 1;
    localparam int TDW = ((4 * W + 7) / 8) * 8;

    // ---------------- window registers ----------------
    logic signed [W-1:0] left_reg, right_reg, bottom_reg, top_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= W'(LEFT_RST);
            right_reg  <= W'(RIGHT_RST);
            bottom_reg <= W'(BOTTOM_RST);
            top_reg    <= W'(TOP_RST);
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_LEFT:   left_reg   <= cfg_data;
                REG_RIGHT:  right_reg  <= cfg_data;
                REG_BOTTOM: bottom_reg <= cfg_data;
                REG_TOP:    top_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // en[i]: stage i loads this cycle. A stage loads when empty or when its
    // successor loads, so a stall freezes only the full run ahead of it.
    logic [NST-1:0] v_reg;
    logic [NST:0]   en;

    assign en[NST] = m_tready;
    for (genvar i = 0; i < NST; i++) begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= s_tvalid;
            for (int i = 1; i < NST; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[OS];

    // ---------------- stage 0: input capture ----------------
    logic signed [W-1:0] x1_0_reg, y1_0_reg, x2_0_reg, y2_0_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x1_0_reg <= s_tdata[W-1:0];
            y1_0_reg <= s_tdata[2*W-1:W];
            x2_0_reg <= s_tdata[3*W-1:2*W];
            y2_0_reg <= s_tdata[4*W-1:3*W];
        end
    end

    // ---------------- stage 1: edge ratios per axis ----------------
    // Each axis yields one entering ratio a/d and one exiting ratio b/d with
    // d = |delta| > 0. An axis with zero delta contributes 0/1 and 1/1.
    logic signed [CW-1:0] dx_c, dy_c, ql_c, qr_c, qb_c, qt_c;
    logic signed [CW-1:0] ax_c, bx_c, xd_c, ay_c, by_c, yd_c;
    logic                 parx_c, pary_c, rej1_c;

    always_comb begin
        dx_c   = {x2_0_reg[W-1], x2_0_reg} - {x1_0_reg[W-1], x1_0_reg};
        dy_c   = {y2_0_reg[W-1], y2_0_reg} - {y1_0_reg[W-1], y1_0_reg};
        ql_c   = {x1_0_reg[W-1], x1_0_reg} - {left_reg[W-1], left_reg};
        qr_c   = {right_reg[W-1], right_reg} - {x1_0_reg[W-1], x1_0_reg};
        qb_c   = {y1_0_reg[W-1], y1_0_reg} - {bottom_reg[W-1], bottom_reg};
        qt_c   = {top_reg[W-1], top_reg} - {y1_0_reg[W-1], y1_0_reg};
        parx_c = (dx_c == '0);
        pary_c = (dy_c == '0);
        if (parx_c) begin
            ax_c = '0;  bx_c = CW'(1);  xd_c = CW'(1);
        end else if (dx_c[CW-1]) begin
            ax_c = -qr_c; bx_c = ql_c;  xd_c = -dx_c;
        end else begin
            ax_c = -ql_c; bx_c = qr_c;  xd_c = dx_c;
        end
        if (pary_c) begin
            ay_c = '0;  by_c = CW'(1);  yd_c = CW'(1);
        end else if (dy_c[CW-1]) begin
            ay_c = -qt_c; by_c = qb_c;  yd_c = -dy_c;
        end else begin
            ay_c = -qb_c; by_c = qt_c;  yd_c = dy_c;
        end
        // zero length, or parallel to an axis and outside its slab
        rej1_c = (parx_c && pary_c)
              || (parx_c && (ql_c[CW-1] || qr_c[CW-1]))
              || (pary_c && (qb_c[CW-1] || qt_c[CW-1]));
    end

    logic signed [CW-1:0] ax_1_reg, bx_1_reg, xd_1_reg, ay_1_reg, by_1_reg, yd_1_reg;
    logic signed [CW-1:0] dx_1_reg, dy_1_reg;
    logic signed [W-1:0]  x1_1_reg, y1_1_reg;
    logic                 bxlt_1_reg, bylt_1_reg, rej_1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            ax_1_reg   <= ax_c;
            bx_1_reg   <= bx_c;
            xd_1_reg   <= xd_c;
            ay_1_reg   <= ay_c;
            by_1_reg   <= by_c;
            yd_1_reg   <= yd_c;
            bxlt_1_reg <= bx_c < xd_c;   // exiting ratio below one
            bylt_1_reg <= by_c < yd_c;
            dx_1_reg   <= dx_c;
            dy_1_reg   <= dy_c;
            x1_1_reg   <= x1_0_reg;
            y1_1_reg   <= y1_0_reg;
            rej_1_reg  <= rej1_c;
        end
    end

    // ---------------- stage 2: entry = max(0,ax,ay), exit = min(1,bx,by) ----
    logic signed [PW-1:0] pa_y_c, pa_x_c, pb_y_c, pb_x_c;
    logic signed [CW-1:0] ea_n_c, ea_d_c, xb_n_c, xb_d_c;
    logic signed [CW-1:0] en_n_c, en_d_c, ex_n_c, ex_d_c;
    logic                 xb_lt_c;

    always_comb begin
        pa_y_c = ay_1_reg * xd_1_reg;
        pa_x_c = ax_1_reg * yd_1_reg;
        pb_y_c = by_1_reg * xd_1_reg;
        pb_x_c = bx_1_reg * yd_1_reg;
        if (pa_y_c > pa_x_c) begin
            ea_n_c = ay_1_reg; ea_d_c = yd_1_reg;
        end else begin
            ea_n_c = ax_1_reg; ea_d_c = xd_1_reg;
        end
        if (pb_y_c < pb_x_c) begin
            xb_n_c = by_1_reg; xb_d_c = yd_1_reg; xb_lt_c = bylt_1_reg;
        end else begin
            xb_n_c = bx_1_reg; xb_d_c = xd_1_reg; xb_lt_c = bxlt_1_reg;
        end
        if (!ea_n_c[CW-1] && ea_n_c != '0) begin
            en_n_c = ea_n_c; en_d_c = ea_d_c;
        end else begin
            en_n_c = '0;     en_d_c = CW'(1);
        end
        if (xb_lt_c) begin
            ex_n_c = xb_n_c; ex_d_c = xb_d_c;
        end else begin
            ex_n_c = CW'(1); ex_d_c = CW'(1);
        end
    end

    logic signed [CW-1:0] en_n_2_reg, en_d_2_reg, ex_n_2_reg, ex_d_2_reg;
    logic signed [CW-1:0] dx_2_reg, dy_2_reg;
    logic signed [W-1:0]  x1_2_reg, y1_2_reg;
    logic                 rej_2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            en_n_2_reg <= en_n_c;
            en_d_2_reg <= en_d_c;
            ex_n_2_reg <= ex_n_c;
            ex_d_2_reg <= ex_d_c;
            dx_2_reg   <= dx_1_reg;
            dy_2_reg   <= dy_1_reg;
            x1_2_reg   <= x1_1_reg;
            y1_2_reg   <= y1_1_reg;
            rej_2_reg  <= rej_1_reg;
        end
    end

    // ---------------- stage 3: empty-interval test and point numerators ----
    // point = start + (n/d)*delta = (start*d + n*delta) / d
    logic signed [PW-1:0] pe_c, px_c;
    logic signed [NW-1:0] nxx_c, nxy_c, nnx_c, nny_c;

    always_comb begin
        pe_c  = en_n_2_reg * ex_d_2_reg;
        px_c  = ex_n_2_reg * en_d_2_reg;
        nxx_c = x1_2_reg * ex_d_2_reg + ex_n_2_reg * dx_2_reg;
        nxy_c = y1_2_reg * ex_d_2_reg + ex_n_2_reg * dy_2_reg;
        nnx_c = x1_2_reg * en_d_2_reg + en_n_2_reg * dx_2_reg;
        nny_c = y1_2_reg * en_d_2_reg + en_n_2_reg * dy_2_reg;
    end

    logic signed [NW-1:0] nxx_3_reg, nxy_3_reg, nnx_3_reg, nny_3_reg;
    logic [W-1:0]         exd_3_reg, end_3_reg;
    logic                 vis_3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            nxx_3_reg <= nxx_c;
            nxy_3_reg <= nxy_c;
            nnx_3_reg <= nnx_c;
            nny_3_reg <= nny_c;
            exd_3_reg <= ex_d_2_reg[W-1:0];
            end_3_reg <= en_d_2_reg[W-1:0];
            vis_3_reg <= !rej_2_reg && !(pe_c > px_c);
        end
    end

    // ---------------- divider stages ----------------
    logic signed [W-1:0] exit_x_q, exit_y_q, entry_x_q, entry_y_q;

    lbc_div #(.COORD_BITS(COORD_BITS)) u_div_exx (
        .aclk(aclk), .en(en[OS-1:DS]), .num(nxx_3_reg), .den(exd_3_reg), .quo(exit_x_q));
    lbc_div #(.COORD_BITS(COORD_BITS)) u_div_exy (
        .aclk(aclk), .en(en[OS-1:DS]), .num(nxy_3_reg), .den(exd_3_reg), .quo(exit_y_q));
    lbc_div #(.COORD_BITS(COORD_BITS)) u_div_enx (
        .aclk(aclk), .en(en[OS-1:DS]), .num(nnx_3_reg), .den(end_3_reg), .quo(entry_x_q));
    lbc_div #(.COORD_BITS(COORD_BITS)) u_div_eny (
        .aclk(aclk), .en(en[OS-1:DS]), .num(nny_3_reg), .den(end_3_reg), .quo(entry_y_q));

    // visible flag rides alongside the dividers
    logic vis_d_reg [0:W];

    for (genvar k = 0; k <= W; k++) begin : g_vis
        always_ff @(posedge aclk) begin
            if (en[DS+k]) vis_d_reg[k] <= (k == 0) ? vis_3_reg : vis_d_reg[(k == 0) ? 0 : k-1];
        end
    end

    // ---------------- output stage ----------------
    logic [TDW-1:0] tdata_reg;
    logic           vis_o_reg;

    always_ff @(posedge aclk) begin
        if (en[OS]) begin
            vis_o_reg <= vis_d_reg[W];
            if (vis_d_reg[W]) begin
                tdata_reg <= TDW'({entry_y_q, entry_x_q, exit_y_q, exit_x_q});
            end else begin
                tdata_reg <= '0;
            end
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = vis_o_reg;

endmodule

// ===== src/lbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
`timescale 1ns / 1ps
module lbc_div import lbc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic [COORD_BITS:0]            en,    // per-stage load enable
    input  logic signed [2*COORD_BITS+2:0] num,
    input  logic [COORD_BITS-1:0]          den,   // positive
    output logic signed [COORD_BITS-1:0]   quo
);
    localparam int W  = COORD_BITS;
    localparam int NW = 2 * COORD_BITS + 3;

    logic [NW-1:0] rem_reg [0:W];
    logic [W-1:0]  quo_reg [0:W];
    logic [W-1:0]  den_reg [0:W];
    logic          neg_reg [0:W];

    // stage 0: split off the sign
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            neg_reg[0] <= num[NW-1];
            rem_reg[0] <= num[NW-1] ? NW'(-num) : NW'(num);
            den_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_step
        localparam int B = W - k;
        logic [NW-1:0] dsh;
        logic          ge;
        logic [W-1:0]  q_next;
        always_comb begin
            dsh       = NW'(den_reg[k-1]) << B;
            ge        = rem_reg[k-1] >= dsh;
            q_next    = quo_reg[k-1];
            q_next[B] = ge;
        end
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k] <= ge ? rem_reg[k-1] - dsh : rem_reg[k-1];
                quo_reg[k] <= q_next;
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign quo = neg_reg[W] ? W'(-quo_reg[W]) : quo_reg[W];

endmodule

// ===== src/lbc_checker.sv =====
// Port-level checks for the line clipper, bound to the top level.
`timescale 1ns / 1ps
module lbc_props import lbc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((4*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    input logic                                   m_tuser
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // rejected segments carry zero coordinates
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("rejected result with nonzero coordinates");

    // an empty output stage never blocks new requests
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind liang_barsky_line_clip lbc_props #(.COORD_BITS(COORD_BITS)) u_lbc_props (.*);

// ===== bench/lbc_checker.sv =====
// Result checker for the line clipper: mirrors window writes, predicts each clip, compares.
`timescale 1ns / 1ps
module lbc_checker import lbc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DW = ((4*COORD_BITS+7)/8)*8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DW-1:0]         s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DW-1:0]         m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COORD_BITS-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef struct packed {
        logic   vis;
        coord_t ex_x, ex_y, en_x, en_y;
    } clip_t;

    longint win_l, win_r, win_b, win_t;
    clip_t  clip_q[$];

    function automatic coord_t lerp_trunc(longint base, longint delta, longint n, longint den);
        longint num;
        num = base * den + n * delta;
        return coord_t'(num / den);
    endfunction

    function automatic clip_t clip_segment(logic [DW-1:0] d);
        coord_t x1c, y1c, x2c, y2c;
        longint x1, y1, dx, dy, n, dd, en_n, en_d, ex_n, ex_d;
        longint p[4], q[4];
        int lo, hi;
        bit ok;
        clip_t r;
        x1c = d[0 +: COORD_BITS];
        y1c = d[COORD_BITS +: COORD_BITS];
        x2c = d[2*COORD_BITS +: COORD_BITS];
        y2c = d[3*COORD_BITS +: COORD_BITS];
        x1 = x1c; y1 = y1c;
        dx = longint'(x2c) - x1; dy = longint'(y2c) - y1;
        en_n = 0; en_d = 1; ex_n = 1; ex_d = 1;
        lo = 0; hi = 3; ok = 1;
        p[0] = -dx; q[0] = x1 - win_l;
        p[1] = dx;  q[1] = win_r - x1;
        p[2] = -dy; q[2] = y1 - win_b;
        p[3] = dy;  q[3] = win_t - y1;
        if (dx == 0 && dy == 0) begin
            ok = 0;
        end else if (dx == 0) begin
            if (q[0] < 0 || q[1] < 0) ok = 0;
            lo = 2;
        end else if (dy == 0) begin
            if (q[2] < 0 || q[3] < 0) ok = 0;
            hi = 1;
        end
        if (ok) begin
            for (int i = lo; i <= hi; i++) begin
                n = q[i]; dd = p[i];
                if (dd < 0) begin
                    n = -n; dd = -dd;
                    if (n * en_d > en_n * dd) begin en_n = n; en_d = dd; end
                end else if (n * ex_d < ex_n * dd) begin
                    ex_n = n; ex_d = dd;
                end
            end
            if (en_n * ex_d > ex_n * en_d) ok = 0;
        end
        r = '0;
        if (ok) begin
            r.vis  = 1'b1;
            r.ex_x = lerp_trunc(x1, dx, ex_n, ex_d);
            r.ex_y = lerp_trunc(y1, dy, ex_n, ex_d);
            r.en_x = lerp_trunc(x1, dx, en_n, en_d);
            r.en_y = lerp_trunc(y1, dy, en_n, en_d);
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        clip_t e;
        coord_t a0, a1, a2, a3;
        if (!aresetn) begin
            win_l <= LEFT_RST; win_r <= RIGHT_RST;
            win_b <= BOTTOM_RST; win_t <= TOP_RST;
            clip_q.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_LEFT:   win_l <= coord_t'(cfg_data);
                    REG_RIGHT:  win_r <= coord_t'(cfg_data);
                    REG_BOTTOM: win_b <= coord_t'(cfg_data);
                    REG_TOP:    win_t <= coord_t'(cfg_data);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                clip_q = {clip_q, clip_segment(s_tdata)};
            if (m_tvalid && m_tready) begin
                a0 = m_tdata[0 +: COORD_BITS];
                a1 = m_tdata[COORD_BITS +: COORD_BITS];
                a2 = m_tdata[2*COORD_BITS +: COORD_BITS];
                a3 = m_tdata[3*COORD_BITS +: COORD_BITS];
                if (clip_q.size() == 0) begin
                    $error("unexpected result: visible %0d", m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    e = clip_q.pop_front();
                    if (e.vis !== m_tuser || e.ex_x !== a0 || e.ex_y !== a1 ||
                        e.en_x !== a2 || e.en_y !== a3)
                        fail_count <= fail_count + 1;
                    if (e.vis !== m_tuser)
                        $error("visible: expected %0d got %0d", e.vis, m_tuser);
                    if (e.ex_x !== a0) $error("exit_x: expected %0d got %0d", e.ex_x, a0);
                    if (e.ex_y !== a1) $error("exit_y: expected %0d got %0d", e.ex_y, a1);
                    if (e.en_x !== a2) $error("entry_x: expected %0d got %0d", e.en_x, a2);
                    if (e.en_y !== a3) $error("entry_y: expected %0d got %0d", e.en_y, a3);
                end
            end
            pending <= clip_q.size();
        end
    end

endmodule

// ===== bench/tb_liang_barsky_line_clip.sv =====
// Testbench top for the line clipper: stimulus, window phases and verdict.
`timescale 1ns / 1ps
module tb_liang_barsky_line_clip;
    import lbc_pkg::*;

    localparam int CB  = COORD_BITS_DEF;
    localparam int DW  = ((4*CB+7)/8)*8;
    localparam int LAT = CB + 6;
    localparam longint CYCLE_LIMIT = 400000;

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          s_tvalid = 0, s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid, m_tready = 0;
    logic [DW-1:0] m_tdata;
    logic          m_tuser;
    logic          cfg_valid = 0, cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CB-1:0] cfg_data = '0;
    int            fail_count, pending;
    longint        cycles = 0;

    // 10 ns clock
    always #5 aclk = ~aclk;

    liang_barsky_line_clip #(.COORD_BITS(CB)) u_top (.*);

    lbc_checker #(.COORD_BITS(CB)) u_chk (.*);

    // Receiver stall pattern: alternates runs of always-ready with random
    // throttling, so back-pressure hits every pipeline phase.
    int stall_mode = 0, stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(5, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Drive one segment request; hold until accepted. The caller decides
    // whether valid drops afterwards.
    task automatic send_seg(input int x1, input int y1, input int x2, input int y2);
        logic [DW-1:0] d;
        d = '0;
        d[0 +: CB]    = CB'(x1);
        d[CB +: CB]   = CB'(y1);
        d[2*CB +: CB] = CB'(x2);
        d[3*CB +: CB] = CB'(y2);
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // One request of a burst, followed by a random gap when gap is set
    task automatic send_burst(input int x1, input int y1, input int x2, input int y2,
                              input bit gap);
        int g;
        send_seg(x1, y1, x2, y2);
        if (gap) begin
            s_tvalid <= 1'b0;
            g = $urandom_range(1, 6);
            repeat (g) @(posedge aclk);
        end
    endtask

    // valid stays up across back-to-back writes; the caller drops it
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input int v);
        cfg_addr  <= a;
        cfg_data  <= CB'(v);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Window change only once the pipeline has drained
    task automatic set_window(input int l, input int r, input int b, input int t);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (LAT + 4) @(posedge aclk);
        write_reg(REG_LEFT, l);
        write_reg(REG_RIGHT, r);
        write_reg(REG_BOTTOM, b);
        write_reg(REG_TOP, t);
        cfg_valid <= 1'b0;
    endtask

    function automatic int rnd_coord();
        return $urandom_range(0, 4095) - 2048;
    endfunction

    // Random coordinate biased toward the window edges
    function automatic int near(input int c);
        int v;
        v = c + $urandom_range(0, 40) - 20;
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return v;
    endfunction

    task automatic random_phase(input int n, input int l, input int r, input int b,
                                input int t);
        int burst, k, x1, y1, x2, y2;
        k = 0;
        while (k < n) begin
            burst = $urandom_range(1, 30);
            for (int j = 0; j < burst && k < n; j++, k++) begin
                case ($urandom_range(0, 5))
                    0: begin
                        x1 = rnd_coord(); y1 = rnd_coord();
                        x2 = rnd_coord(); y2 = rnd_coord();
                    end
                    1: begin x1 = near(l); y1 = near(b); x2 = near(r); y2 = near(t); end
                    2: begin x1 = rnd_coord(); y1 = rnd_coord(); x2 = x1; y2 = rnd_coord(); end
                    3: begin x1 = rnd_coord(); y1 = rnd_coord(); x2 = rnd_coord(); y2 = y1; end
                    4: begin
                        x1 = near(l); y1 = near(t); x2 = near(r); y2 = near(b);
                    end
                    default: begin
                        // each endpoint has one coordinate near a window edge
                        x1 = near(($urandom_range(0, 1)) ? l : r);
                        y1 = rnd_coord();
                        x2 = rnd_coord();
                        y2 = near(($urandom_range(0, 1)) ? b : t);
                    end
                endcase
                // last request of a burst is followed by a gap
                send_burst(x1, y1, x2, y2, (j == burst - 1) || (k == n - 1));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: default window 0..1023 x 0..719
        send_burst(100, 100, 100, 100, 0);        // zero length
        send_burst(-5, -100, -5, 800, 0);         // vertical, left of window
        send_burst(1500, 0, 1500, 300, 0);        // vertical, right of window
        send_burst(10, -9, 500, -9, 0);           // horizontal, below
        send_burst(10, 900, 500, 900, 0);         // horizontal, above
        send_burst(500, -100, 500, 900, 0);       // vertical through
        send_burst(-100, 300, 1200, 300, 0);      // horizontal through
        send_burst(-2048, -2048, 2047, 2047, 0);  // full extremes
        send_burst(2047, 2047, -2048, -2048, 0);
        send_burst(-2048, 2047, 2047, -2048, 1);
        send_burst(0, 0, 1023, 719, 0);           // corner to corner
        send_burst(1023, 0, 1100, -50, 0);        // touch at a corner: entry == exit
        send_burst(-100, 0, 0, -100, 0);          // grazes corner from outside
        send_burst(10, 10, 20, 30, 0);            // fully inside
        send_burst(-500, 1000, -400, 1500, 1);    // fully outside
        send_burst(-1, -1, 1, 1, 0);              // odd truncation at origin
        send_burst(-2048, 5, 2047, 6, 0);
        send_burst(1023, 719, 1024, 720, 0);
        send_burst(0, 719, -1, 720, 0);

        // Extreme and inverted windows
        set_window(-2048, 2047, -2048, 2047);
        send_burst(-2048, -2048, 2047, 2047, 0);
        send_burst(2047, -2048, -2048, 2047, 0);
        send_burst(-2048, 0, -2048, 5, 1);
        set_window(100, -100, 50, -50);           // inverted
        send_burst(-200, 0, 200, 0, 0);
        send_burst(0, -200, 0, 200, 1);

        random_phase(350, 100, -100, 50, -50);
        set_window(-300, 300, -200, 200);
        random_phase(400, -300, 300, -200, 200);
        set_window(-2048, 2047, -2048, 2047);
        random_phase(250, -2048, 2047, -2048, 2047);
        set_window(5, 5, -7, -7);                 // single-point window
        random_phase(150, 5, 5, -7, -7);
        set_window(-1900, 1800, 600, 2047);
        random_phase(400, -1900, 1800, 600, 2047);

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (LAT + 4) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== files.f =====
src/lbc_pkg.sv
src/lbc_div.sv
src/liang_barsky_line_clip.sv
src/lbc_checker.sv
bench/lbc_checker.sv
bench/tb_liang_barsky_line_clip.sv
